// ===== design/cpvd_pkg.sv =====
// Package for the channel-state presence detector.
// Holds widths, defaults, register indices and reset values; no dependencies.
package cpvd_pkg;
    localparam int WINDOW_DEF    = 50;
    localparam int MAX_PAIRS_DEF = 30;
    localparam int THR_W         = 23;
    localparam int MINE_W        = 6;
    localparam int AMP_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ENTRIES = 1'b1;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 23'd1280;
    localparam logic [MINE_W-1:0] MIN_ENTRIES_RESET = 6'd10;
endpackage

// ===== design/cpvd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module cpvd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/cpvd_divider.sv =====
// Restoring divider: one quotient bit per cycle.
// No dependencies.
module cpvd_divider #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    assign trial = {rem_reg[DW-1:0], q_reg[NW-1]};
    assign quot  = q_reg;
    assign done  = done_reg;

    // Shift one numerator bit in and trial-subtract each cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW);
            q_reg    <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
            cnt_reg  <= cnt_reg - CW'(1);
            // Flag the quotient as final together with the last step
            done_reg <= (cnt_reg == CW'(1));
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end
endmodule

// ===== design/csi_presence_variance_detector.sv =====
// Presence detector on CSI amplitude spread. One I/Q pair is taken per item;
// each pair's magnitude comes from a bit-serial square root of 16 steps. A final
// pair of a packet with two or more pairs also runs a mean division, writes the
// amplitude ring, walks the ring once through the single RAM read port, and runs
// one 46-step variance division (skipped while too few entries are stored); a
// pending result may also wait for out_ready. The block is not ready while any
// of this work runs. The ring needs no clearing pass.
// Depends on cpvd_pkg, cpvd_ram and cpvd_divider.
module csi_presence_variance_detector #(
    parameter int WINDOW    = cpvd_pkg::WINDOW_DEF,
    parameter int MAX_PAIRS = cpvd_pkg::MAX_PAIRS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cpvd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpvd_pkg::THR_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [7:0]              in_phase,
    input  logic signed [7:0]              quadrature,
    input  logic                           last_pair,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [22:0]                    variance,
    output logic                           presence,
    output logic [5:0]                     window_fill
);
    import cpvd_pkg::*;

    localparam int AW  = $clog2(WINDOW);
    localparam int FW  = $clog2(WINDOW + 1);
    localparam int PW  = $clog2(MAX_PAIRS + 1);
    localparam int MSW = AMP_W + PW;
    localparam int SW  = AMP_W + FW;
    localparam int TW  = 2 * AMP_W + FW;
    localparam int NW  = 2 * SW + 2;
    localparam int DW  = 2 * FW + 8;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQRT = 4'd1;
    localparam logic [3:0] ST_MEAN = 4'd2;
    localparam logic [3:0] ST_MWAIT = 4'd3;
    localparam logic [3:0] ST_WRITE = 4'd4;
    localparam logic [3:0] ST_WALK = 4'd5;
    localparam logic [3:0] ST_SQ = 4'd6;
    localparam logic [3:0] ST_VAR = 4'd7;
    localparam logic [3:0] ST_VWAIT = 4'd8;
    localparam logic [3:0] ST_OUT = 4'd9;

    logic [3:0]        state_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [MINE_W-1:0] mine_reg;
    logic [AW-1:0]     slot_reg;
    logic [FW-1:0]     fill_reg;
    logic [PW-1:0]     pcnt_reg;
    logic [MSW-1:0]    msum_reg;
    logic              last_reg;
    // Square root registers: 32-bit radicand, 16-bit root
    logic [31:0]       rad_reg;
    logic [16:0]       rem_reg;
    logic [15:0]       root_reg;
    logic [3:0]        sstep_reg;
    // Ring walk
    logic [AW-1:0]     raddr_reg;
    logic [FW-1:0]     rcnt_reg;
    logic              rvld_reg;
    logic [SW-1:0]     s_reg;
    logic [TW-1:0]     t_reg;
    logic [AMP_W-1:0]  mean_reg;
    logic [NW-1:0]     num_reg;
    logic [22:0]       var_reg;
    // Result item held for the output side
    logic [22:0]       var_out_reg;
    logic [5:0]        fill_out_reg;
    logic              pres_reg;
    logic              ovld_reg;

    logic [AMP_W-1:0]  rdata;
    logic              dv_start;
    logic [NW-1:0]     dv_num;
    logic [DW-1:0]     dv_den;
    logic              dv_done;
    logic [NW-1:0]     dv_quot;
    logic [18:0]       sq_trial;
    logic [18:0]       sq_sub;
    logic [15:0]       energy;
    logic [2*AMP_W-1:0] a_sq;
    logic              enough;
    logic [FW-1:0]     fill_new;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = ovld_reg;
    assign variance    = var_out_reg;
    assign presence    = pres_reg;
    assign window_fill = fill_out_reg;

    assign energy   = 16'($signed(in_phase) * $signed(in_phase))
                    + 16'($signed(quadrature) * $signed(quadrature));
    assign sq_trial = {rem_reg, rad_reg[31:30]};
    assign sq_sub   = {1'b0, root_reg, 2'b01};
    assign a_sq     = rdata * rdata;
    assign enough   = (fill_reg != '0) && (32'(fill_reg) >= 32'(mine_reg));
    assign fill_new = (fill_reg < FW'(WINDOW)) ? fill_reg + FW'(1) : fill_reg;

    // Shared divider: mean, then variance
    assign dv_start = (state_reg == ST_MEAN) || (state_reg == ST_VAR);
    assign dv_num   = (state_reg == ST_MEAN) ? NW'(msum_reg) : num_reg;
    assign dv_den   = (state_reg == ST_MEAN) ? DW'(pcnt_reg)
                    : DW'({(2 * FW)'(fill_reg) * (2 * FW)'(fill_reg), 8'd0});

    cpvd_divider #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quot  (dv_quot)
    );

    cpvd_ram #(.WIDTH(AMP_W), .DEPTH(WINDOW)) u_ring (
        .clk   (clk),
        .we    (state_reg == ST_WRITE),
        .waddr (slot_reg),
        .wdata (mean_reg),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RESET;
            mine_reg <= MIN_ENTRIES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD:   thr_reg  <= cfg_data;
                REG_MIN_ENTRIES: mine_reg <= cfg_data[MINE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
            pcnt_reg  <= '0;
            msum_reg  <= '0;
            ovld_reg  <= 1'b0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            if (ovld_reg && out_ready && (state_reg != ST_OUT))
            begin
                ovld_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg  <= last_pair;
                        rad_reg   <= {energy, 16'd0};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        sstep_reg <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    // One root bit per cycle, 16 bits; the last step accumulates
                    if (sstep_reg == 4'd15)
                    begin
                        if (pcnt_reg < PW'(MAX_PAIRS))
                        begin
                            msum_reg <= msum_reg + MSW'((sq_trial >= sq_sub)
                                        ? {root_reg[14:0], 1'b1} : {root_reg[14:0], 1'b0});
                            pcnt_reg <= pcnt_reg + PW'(1);
                        end
                        if (!last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_MEAN;
                        end
                    end
                    if (sq_trial >= sq_sub)
                    begin
                        rem_reg  <= 17'(sq_trial - sq_sub);
                        root_reg <= {root_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= 17'(sq_trial);
                        root_reg <= {root_reg[14:0], 1'b0};
                    end
                    rad_reg   <= {rad_reg[29:0], 2'b00};
                    sstep_reg <= sstep_reg + 4'd1;
                end
                ST_MEAN:
                begin
                    // Drop short packets
                    if (pcnt_reg < PW'(2))
                    begin
                        pcnt_reg  <= '0;
                        msum_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_MWAIT;
                    end
                end
                ST_MWAIT:
                begin
                    if (dv_done)
                    begin
                        mean_reg  <= AMP_W'(dv_quot);
                        pcnt_reg  <= '0;
                        msum_reg  <= '0;
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    slot_reg  <= (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + AW'(1);
                    fill_reg  <= fill_new;
                    raddr_reg <= '0;
                    rcnt_reg  <= '0;
                    rvld_reg  <= 1'b0;
                    s_reg     <= '0;
                    t_reg     <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    // Issue one read per cycle; accumulate the previous read
                    if (rvld_reg)
                    begin
                        s_reg <= s_reg + SW'(rdata);
                        t_reg <= t_reg + TW'(a_sq);
                    end
                    if (rcnt_reg < fill_reg)
                    begin
                        raddr_reg <= AW'(rcnt_reg);
                        rcnt_reg  <= rcnt_reg + FW'(1);
                        rvld_reg  <= (rcnt_reg != '0);
                    end
                    else
                    begin
                        // The read of the last entry lands next cycle
                        rvld_reg  <= 1'b1;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (rvld_reg)
                    begin
                        s_reg    <= s_reg + SW'(rdata);
                        t_reg    <= t_reg + TW'(a_sq);
                        rvld_reg <= 1'b0;
                    end
                    else
                    begin
                        num_reg   <= NW'(fill_reg * t_reg) - NW'(s_reg * s_reg);
                        state_reg <= enough ? ST_VAR : ST_OUT;
                        if (!enough)
                        begin
                            var_reg <= '0;
                        end
                    end
                end
                ST_VAR:
                begin
                    state_reg <= ST_VWAIT;
                end
                ST_VWAIT:
                begin
                    if (dv_done)
                    begin
                        var_reg   <= (dv_quot > NW'(23'h7FFFFF)) ? 23'h7FFFFF : 23'(dv_quot);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!ovld_reg || out_ready)
                    begin
                        var_out_reg  <= var_reg;
                        fill_out_reg <= 6'(fill_reg);
                        pres_reg     <= (var_reg > thr_reg);
                        ovld_reg     <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== design/cpvd_checker.sv =====
// Port-level checks for the presence detector, bound to the top level.
// Depends on cpvd_pkg and csi_presence_variance_detector.
module cpvd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [22:0] variance,
    input logic        presence,
    input logic [5:0]  window_fill
);
    import cpvd_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(variance))
        else $error("result changed while stalled");

    // Presence needs nonzero variance
    a_pres: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && presence |-> variance != '0)
        else $error("presence with zero variance");

    // A result always has a stored entry
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> window_fill != '0)
        else $error("result with empty window");

    // An accepted item makes the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");
endmodule

bind csi_presence_variance_detector cpvd_checker u_cpvd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .variance    (variance),
    .presence    (presence),
    .window_fill (window_fill)
);

// ===== verif/csi_presence_variance_detector_tb.sv =====
// Testbench for csi_presence_variance_detector: directed packet table, then random
// packets over several register settings, checked against an in-bench predictor.
// Depends on cpvd_pkg and the detector RTL.
`timescale 1ns / 100ps

module csi_presence_variance_detector_tb;
    import cpvd_pkg::*;

    localparam int RING_DEPTH = 50;
    localparam int PAIR_LIMIT = 30;
    localparam int SETTLE     = 250;
    localparam int CYCLE_CAP  = 3000000;

    typedef struct packed {
        logic [22:0] variance;
        logic        presence;
        logic [5:0]  window_fill;
    } verdict_t;

    typedef struct {
        logic signed [7:0] i_val;
        logic signed [7:0] q_val;
        logic              last;
        logic [5:0]        fill;   // typed fill of the result, variance is 0
    } pair_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [7:0]    in_phase;
    logic signed [7:0]    quadrature;
    logic                 last_pair;
    logic                 out_valid;
    logic                 out_ready;
    logic [22:0]          variance;
    logic                 presence;
    logic [5:0]           window_fill;

    csi_presence_variance_detector dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_phase(in_phase), .quadrature(quadrature), .last_pair(last_pair),
        .out_valid(out_valid), .out_ready(out_ready),
        .variance(variance), .presence(presence), .window_fill(window_fill)
    );

    // Predictor state
    logic [15:0]      amp_ring [RING_DEPTH];
    int unsigned      slot_ptr;
    int unsigned      stored;
    int unsigned      pairs_seen;
    int unsigned      mag_acc;
    logic [THR_W-1:0] thr_reg;
    logic [5:0]       min_reg;

    verdict_t    pending_verdicts[$];
    int          fail_count;
    logic        quiet;       // no idling on either side in this stretch
    logic        typed_on;    // directed row: push the typed verdict
    logic [5:0]  typed_fill;
    int unsigned cycle_no;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned root;
        int unsigned bitv;
        root = 0;
        bitv = 32'h4000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [22:0] spread_of_ring();
        longint unsigned n;
        longint unsigned s;
        longint unsigned t;
        longint unsigned quo;
        n = stored;
        s = 0;
        t = 0;
        if (n == 0 || n < min_reg)
            return '0;
        for (int k = 0; k < stored; k++)
        begin
            s += amp_ring[k];
            t += longint'(amp_ring[k]) * amp_ring[k];
        end
        quo = (n * t - s * s) / (n * n * 256);
        return (quo > 64'd8388607) ? 23'h7FFFFF : quo[22:0];
    endfunction

    // Advance the predictor by one accepted pair
    task automatic absorb_pair(logic signed [7:0] iv, logic signed [7:0] qv, logic fin);
        int          energy;
        int unsigned avg;
        verdict_t    vd;
        if (pairs_seen < PAIR_LIMIT)
        begin
            energy = int'(iv) * int'(iv) + int'(qv) * int'(qv);
            mag_acc += int_sqrt(energy << 16);
            pairs_seen++;
        end
        if (fin)
        begin
            if (pairs_seen < 2)
            begin
                pairs_seen = 0;
                mag_acc = 0;
            end
            else
            begin
                avg = mag_acc / pairs_seen;
                pairs_seen = 0;
                mag_acc = 0;
                amp_ring[slot_ptr] = avg[15:0];
                slot_ptr = (slot_ptr + 1 >= RING_DEPTH) ? 0 : slot_ptr + 1;
                if (stored < RING_DEPTH)
                    stored++;
                vd.variance = spread_of_ring();
                vd.presence = vd.variance > thr_reg;
                vd.window_fill = stored[5:0];
                if (typed_on)
                begin
                    vd.variance = '0;
                    vd.presence = 1'b0;
                    vd.window_fill = typed_fill;
                end
                pending_verdicts.push_back(vd);
            end
        end
    endtask

    // Predict on input items, check output items
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && in_valid && in_ready)
            absorb_pair(in_phase, quadrature, last_pair);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result item: variance %0d presence %0d fill %0d",
                       variance, presence, window_fill);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (variance !== want.variance)
                begin
                    $error("variance: expected %0d actual %0d", want.variance, variance);
                    fail_count++;
                end
                if (presence !== want.presence)
                begin
                    $error("presence: expected %0d actual %0d", want.presence, presence);
                    fail_count++;
                end
                if (window_fill !== want.window_fill)
                begin
                    $error("window_fill: expected %0d actual %0d",
                           want.window_fill, window_fill);
                    fail_count++;
                end
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_no++;
        if (cycle_no > CYCLE_CAP)
        begin
            $display("csi_presence_variance_detector: mismatch");
            $finish;
        end
    end

    // Result side: stall a random count per item, then hold ready until taken
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
                @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Send one pair; entered and left at a falling edge
    task automatic send_pair(logic signed [7:0] iv, logic signed [7:0] qv, logic fin);
        int gap;
        logic taken;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_phase = iv;
        quadrature = qv;
        last_pair = fin;
        in_valid = 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = in_ready;
        end
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == REG_THRESHOLD)
            thr_reg = val;
        else
            min_reg = val[5:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Hold until every verdict has come, then let in-flight work settle
    task automatic drain();
        in_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // One random packet: mostly normal lengths, some short, some over-long
    task automatic random_packet();
        int len;
        int sel;
        int lvl;
        logic signed [7:0] iv;
        logic signed [7:0] qv;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            len = 1;
        else if (sel == 1)
            len = $urandom_range(31, 40);
        else
            len = $urandom_range(2, 12);
        lvl = $urandom_range(0, 3) == 0 ? 127 : $urandom_range(0, 127);
        for (int k = 0; k < len; k++)
        begin
            iv = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, lvl));
            qv = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, lvl));
            if ($urandom_range(0, 1))
                iv = -iv;
            if ($urandom_range(0, 1))
                qv = -qv;
            send_pair(iv, qv, k == len - 1);
        end
    endtask

    pair_row_t lead_rows[13] = '{
        '{8'sd127,  8'sd127,  1'b0, 6'd0},
        '{-8'sd128, -8'sd128, 1'b1, 6'd1},
        '{-8'sd128, 8'sd127,  1'b0, 6'd0},
        '{8'sd127,  -8'sd128, 1'b1, 6'd2},
        '{8'sd0,    8'sd0,    1'b1, 6'd0},   // short packet, dropped
        '{8'sd0,    8'sd0,    1'b0, 6'd0},
        '{8'sd0,    8'sd0,    1'b1, 6'd3},
        '{8'sd1,    -8'sd1,   1'b0, 6'd0},
        '{-8'sd1,   8'sd1,    1'b0, 6'd0},
        '{8'sd64,   -8'sd64,  1'b1, 6'd4},
        '{-8'sd128, 8'sd0,    1'b1, 6'd0},   // short packet, dropped
        '{8'sd0,    8'sd127,  1'b0, 6'd0},
        '{8'sd0,    -8'sd128, 1'b1, 6'd5}
    };

    logic [THR_W-1:0] thr_plan [8] = '{23'd0, 23'h7FFFFF, 23'd1280, 23'd64,
                                       23'd0, 23'd4000, 23'd300, 23'd0};
    logic [5:0]       min_plan [8] = '{6'd1, 6'd50, 6'd0, 6'd2,
                                       6'd63, 6'd10, 6'd1, 6'd25};

    initial
    begin
        fail_count = 0;
        cycle_no = 0;
        quiet = 1'b0;
        typed_on = 1'b0;
        typed_fill = '0;
        slot_ptr = 0;
        stored = 0;
        pairs_seen = 0;
        mag_acc = 0;
        thr_reg = THRESHOLD_RESET;
        min_reg = MIN_ENTRIES_RESET;
        foreach (amp_ring[k])
            amp_ring[k] = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_phase = '0;
        quadrature = '0;
        last_pair = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table under reset settings
        typed_on = 1'b1;
        foreach (lead_rows[r])
        begin
            typed_fill = lead_rows[r].fill;
            send_pair(lead_rows[r].i_val, lead_rows[r].q_val, lead_rows[r].last);
        end
        drain();
        typed_on = 1'b0;

        // Random phases across register settings
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_THRESHOLD, p == 7 ? 23'($urandom) : thr_plan[p]);
            write_reg(REG_MIN_ENTRIES, p == 6 ? 23'($urandom_range(1, 50)) : 23'(min_plan[p]));
            quiet = (p == 3);
            for (int k = 0; k < 27; k++)
                random_packet();
            drain();
        end
        quiet = 1'b0;

        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("csi_presence_variance_detector: match");
        else
            $display("csi_presence_variance_detector: mismatch");
        $finish;
    end
endmodule
